// File: rtl/wsfe_pkg.sv
package wsfe_pkg;

  // request kinds
  localparam logic REQ_HEADER  = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  // length field encodings (RFC 6455)
  localparam logic [62:0] LEN7_MAX  = 63'd125;
  localparam logic [62:0] LEN16_MAX = 63'd65535;
  localparam logic [7:0]  CODE16    = 8'd126;
  localparam logic [7:0]  CODE64    = 8'd127;
  localparam logic [3:0]  OPCODE_MASK = 4'hf;

  // header length formats chosen by the front end
  localparam logic [1:0] FMT_SHORT = 2'd0;
  localparam logic [1:0] FMT_LEN16 = 2'd1;
  localparam logic [1:0] FMT_LEN64 = 2'd2;

  // byte position of the last header byte per format
  localparam logic [3:0] LAST_SHORT = 4'd1;
  localparam logic [3:0] LAST_LEN16 = 4'd3;
  localparam logic [3:0] LAST_LEN64 = 4'd9;

  typedef struct packed {
    logic        req_type;
    logic        fin_bit;
    logic [3:0]  opcode;
    logic [62:0] payload_length;
    logic [7:0]  payload_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       end_of_frame;
    logic       last_of_run;
    logic       status;
  } out_res_t;

  // classified command passed from front end to back end
  typedef struct packed {
    logic        is_hdr;
    logic [1:0]  fmt;
    logic [7:0]  byte0;
    logic [62:0] len;
    logic        len_zero;
    logic [7:0]  data;
    logic        eof;
    logic        status;
  } cmd_t;

endpackage

// File: rtl/wsfe_front.sv
module wsfe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  wsfe_pkg::in_req_t req,
  output logic              push,
  output wsfe_pkg::cmd_t    cmd
);

  logic [62:0] rem_r, rem_nxt;
  logic        rem_zero;

  assign rem_zero = (rem_r == 63'd0);
  assign push     = acc;

  // classify request, build command
  always_comb begin
    cmd          = '0;
    cmd.is_hdr   = (req.req_type == wsfe_pkg::REQ_HEADER);
    cmd.byte0    = {req.fin_bit, 3'b000, req.opcode & wsfe_pkg::OPCODE_MASK};
    cmd.len      = req.payload_length;
    cmd.len_zero = (req.payload_length == 63'd0);
    cmd.data     = req.payload_byte;
    if (req.payload_length <= wsfe_pkg::LEN7_MAX) begin
      cmd.fmt = wsfe_pkg::FMT_SHORT;
    end else if (req.payload_length <= wsfe_pkg::LEN16_MAX) begin
      cmd.fmt = wsfe_pkg::FMT_LEN16;
    end else begin
      cmd.fmt = wsfe_pkg::FMT_LEN64;
    end
    cmd.status = !cmd.is_hdr && rem_zero;
    cmd.eof    = !cmd.is_hdr && (rem_r == 63'd1);
  end

  // payload bytes still due
  always_comb begin
    rem_nxt = rem_r;
    if (acc) begin
      if (req.req_type == wsfe_pkg::REQ_HEADER) begin
        rem_nxt = req.payload_length;
      end else if (!rem_zero) begin
        rem_nxt = rem_r - 63'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

// File: rtl/wsfe_queue.sv
module wsfe_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wsfe_pkg::cmd_t wr_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output wsfe_pkg::cmd_t rd_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  wsfe_pkg::cmd_t   entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_cmd    = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty))
    else $error("pop from empty queue");

endmodule

// File: rtl/wsfe_back.sv
module wsfe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  wsfe_pkg::cmd_t     cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output wsfe_pkg::out_res_t out_data
);

  logic [3:0]         idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  wsfe_pkg::out_res_t out_data_r, res;
  logic [3:0]         last_idx;
  logic               is_last;
  logic               load;
  logic [63:0]        len64;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign len64     = {1'b0, cmd.len};

  // output register free or being drained
  assign load = cmd_valid && (!out_valid_r || !out_stall);

  always_comb begin
    unique case (cmd.fmt)
      wsfe_pkg::FMT_SHORT: last_idx = wsfe_pkg::LAST_SHORT;
      wsfe_pkg::FMT_LEN16: last_idx = wsfe_pkg::LAST_LEN16;
      default:             last_idx = wsfe_pkg::LAST_LEN64;
    endcase
  end

  assign is_last = !cmd.is_hdr || (idx_r == last_idx);
  assign pop     = load && is_last;

  // select the byte for the current position
  always_comb begin
    res = '0;
    if (cmd.is_hdr) begin
      res.is_header    = 1'b1;
      res.last_of_run  = is_last;
      res.end_of_frame = is_last && cmd.len_zero;
      case (idx_r)
        4'd0: res.out_byte = cmd.byte0;
        4'd1: begin
          unique case (cmd.fmt)
            wsfe_pkg::FMT_SHORT: res.out_byte = {1'b0, cmd.len[6:0]};
            wsfe_pkg::FMT_LEN16: res.out_byte = wsfe_pkg::CODE16;
            default:             res.out_byte = wsfe_pkg::CODE64;
          endcase
        end
        4'd2: res.out_byte = (cmd.fmt == wsfe_pkg::FMT_LEN16) ? len64[15:8] : len64[63:56];
        4'd3: res.out_byte = (cmd.fmt == wsfe_pkg::FMT_LEN16) ? len64[7:0] : len64[55:48];
        4'd4: res.out_byte = len64[47:40];
        4'd5: res.out_byte = len64[39:32];
        4'd6: res.out_byte = len64[31:24];
        4'd7: res.out_byte = len64[23:16];
        4'd8: res.out_byte = len64[15:8];
        default: res.out_byte = len64[7:0];
      endcase
    end else begin
      res.out_byte     = cmd.status ? 8'd0 : cmd.data;
      res.end_of_frame = cmd.eof;
      res.last_of_run  = 1'b1;
      res.status       = cmd.status;
    end
  end

  // header byte position and output valid
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = is_last ? 4'd0 : idx_r + 4'd1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= wsfe_pkg::LAST_LEN64)
    else $error("header byte position out of range");

  a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == 4'd0))
    else $error("byte position not cleared after pop");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status) |-> (out_data_r.last_of_run && !out_data_r.is_header))
    else $error("dropped byte result malformed");

endmodule

// File: rtl/websocket_frame_encoder.sv
// Each accepted request is queued, then loaded into the back end's output register.
// Throughput: one payload request per cycle unless stalled; a header request emits
//   2, 4 or 10 bytes, one per cycle, from the back end's single output register.
// The request queue (QUEUE_DEPTH entries) absorbs input while headers drain.
// Reset (rst_n low, synchronous) clears the byte-due counter, queue and out_valid.
module websocket_frame_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wsfe_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wsfe_pkg::out_res_t out_data
);

  logic           acc;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_not_empty;
  wsfe_pkg::cmd_t front_cmd;
  wsfe_pkg::cmd_t head_cmd;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  wsfe_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .req   (in_data),
    .push  (push),
    .cmd   (front_cmd)
  );

  wsfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_cmd    (front_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_cmd    (head_cmd)
  );

  wsfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  wsfe_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wsfe_pkg::out_res_t out_data;

  // idling odds in percent, per cycle
  int send_gap_pct = 0;
  int stall_pct = 0;

  // predictor state and expected output stream
  logic [63:0] bytes_due = '0;
  wsfe_pkg::out_res_t expected_stream[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int n_requests = 0;
  int n_headers = 0;
  int n_payload = 0;
  int n_stray = 0;
  int n_checked = 0;

  websocket_frame_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still due out", cycle_count,
               expected_stream.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Works out the bytes one request produces and queues them.
  function automatic void encode_request(wsfe_pkg::in_req_t r);
    logic [7:0] hdr [10];
    logic [63:0] wide;
    wsfe_pkg::out_res_t res;
    int n;
    int i;
    n_requests++;
    if (r.req_type == wsfe_pkg::REQ_HEADER) begin
      n_headers++;
      wide = {1'b0, r.payload_length};
      hdr[0] = {r.fin_bit, 3'b000, r.opcode & wsfe_pkg::OPCODE_MASK};
      if (r.payload_length <= wsfe_pkg::LEN7_MAX) begin
        hdr[1] = wide[7:0];
        n = 2;
      end else if (r.payload_length <= wsfe_pkg::LEN16_MAX) begin
        hdr[1] = wsfe_pkg::CODE16;
        hdr[2] = wide[15:8];
        hdr[3] = wide[7:0];
        n = 4;
      end else begin
        hdr[1] = wsfe_pkg::CODE64;
        for (i = 0; i < 8; i++) hdr[2 + i] = wide[56 - 8 * i +: 8];
        n = 10;
      end
      for (i = 0; i < n; i++) begin
        res.out_byte = hdr[i];
        res.is_header = 1'b1;
        res.end_of_frame = (i == n - 1) && (wide == 64'd0);
        res.last_of_run = (i == n - 1);
        res.status = 1'b0;
        expected_stream.push_back(res);
      end
      // a new header abandons any frame still open
      bytes_due = wide;
    end else if (bytes_due == 64'd0) begin
      // nothing due: byte is flagged and dropped
      n_stray++;
      res = '{out_byte: 8'h00, is_header: 1'b0, end_of_frame: 1'b0,
              last_of_run: 1'b1, status: 1'b1};
      expected_stream.push_back(res);
    end else begin
      n_payload++;
      bytes_due = bytes_due - 64'd1;
      res = '{out_byte: r.payload_byte, is_header: 1'b0,
              end_of_frame: (bytes_due == 64'd0), last_of_run: 1'b1, status: 1'b0};
      expected_stream.push_back(res);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // output stream checker
  always @(posedge clk) begin
    wsfe_pkg::out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_checked++;
      if (expected_stream.size() == 0) begin
        $error("output byte %0h arrived with nothing expected", out_data.out_byte);
        mismatch_count++;
      end else begin
        want = expected_stream.pop_front();
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("is_header", 8'(want.is_header), 8'(out_data.is_header));
        check_field("end_of_frame", 8'(want.end_of_frame), 8'(out_data.end_of_frame));
        check_field("last_of_run", 8'(want.last_of_run), 8'(out_data.last_of_run));
        check_field("status", 8'(want.status), 8'(out_data.status));
      end
    end
  end

  function automatic wsfe_pkg::in_req_t make_header(logic fin, logic [3:0] op,
                                                    logic [62:0] len);
    wsfe_pkg::in_req_t r;
    r.req_type = wsfe_pkg::REQ_HEADER;
    r.fin_bit = fin;
    r.opcode = op;
    r.payload_length = len;
    r.payload_byte = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // payload request with junk in the header-only fields
  function automatic wsfe_pkg::in_req_t make_payload(logic [7:0] data);
    wsfe_pkg::in_req_t r;
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    r.req_type = wsfe_pkg::REQ_PAYLOAD;
    r.fin_bit = junk[63];
    r.opcode = junk[3:0];
    r.payload_length = junk[62:0];
    r.payload_byte = data;
    return r;
  endfunction

  // Offers one request and holds it until accepted.
  task automatic send_request(wsfe_pkg::in_req_t r);
    logic [95:0] junk;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      @(negedge clk);
      junk = {$urandom, $urandom, $urandom};
      in_valid <= 1'b0;
      in_data <= junk[$bits(wsfe_pkg::in_req_t)-1:0];
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    encode_request(r);
  endtask

  // Drops valid and waits for every expected byte.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_stream.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_frames();
    // empty payload, then a short frame with extreme data bytes
    send_request(make_header(1'b1, 4'd1, 63'd0));
    send_request(make_header(1'b0, 4'd2, 63'd3));
    send_request(make_payload(8'h00));
    send_request(make_payload(8'hff));
    send_request(make_payload(8'ha5));
  endtask

  task automatic test_length_encodings();
    // each length boundary; most frames are abandoned by the next header
    send_request(make_header(1'b1, 4'd15, 63'd125));
    send_request(make_payload(8'h11));
    send_request(make_payload(8'h22));
    send_request(make_header(1'b0, 4'd0, 63'd126));
    send_request(make_payload(8'h33));
    send_request(make_header(1'b1, 4'd2, 63'd65535));
    send_request(make_header(1'b0, 4'd9, 63'd65536));
    send_request(make_header(1'b1, 4'd1, {63{1'b1}}));
    send_request(make_header(1'b1, 4'd8, 63'd1));
    send_request(make_payload(8'hc3));
  endtask

  task automatic test_unexpected_bytes();
    send_request(make_payload(8'h5a));
    send_request(make_payload(8'hff));
    send_request(make_header(1'b0, 4'd10, 63'd0));
    send_request(make_payload(8'h01));
  endtask

  // Mostly well-formed frames with random content, some cut short or overrun.
  task automatic test_random_traffic(int n_items);
    int first;
    int pick;
    int n_bytes;
    int k;
    logic [62:0] len;
    logic [63:0] wide;
    first = n_requests;
    while (n_requests - first < n_items) begin
      pick = $urandom_range(0, 99);
      wide = {$urandom, $urandom};
      if (pick < 70) begin
        len = 63'($urandom_range(0, 12));
      end else if (pick < 80) begin
        len = 63'($urandom_range(126, 65535));
      end else if (pick < 88) begin
        len = wide[62:0] >> $urandom_range(0, 46);
        if (len <= wsfe_pkg::LEN16_MAX) len = len + 63'd65536;
      end else begin
        len = 63'($urandom_range(100, 125));
      end
      n_bytes = (len > 63'd16) ? int'($urandom_range(0, 3)) : int'(len);
      pick = $urandom_range(0, 99);
      if (pick < 8 && n_bytes > 0) n_bytes--;
      else if (pick < 16) n_bytes++;
      send_request(make_header(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), len));
      for (k = 0; k < n_bytes; k++) send_request(make_payload(8'($urandom_range(0, 255))));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver stalls often
    send_gap_pct = 6;
    stall_pct = 55;
    test_basic_frames();
    test_length_encodings();
    test_unexpected_bytes();
    test_random_traffic(44);
    wait_drain();

    // sender idles often, receiver rarely stalls
    send_gap_pct = 55;
    stall_pct = 6;
    test_random_traffic(44);
    wait_drain();

    // full rate both ways
    send_gap_pct = 0;
    stall_pct = 0;
    test_random_traffic(44);
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d headers, %0d payload bytes, %0d unexpected bytes.",
             n_requests, n_headers, n_payload, n_stray);
    $display("Checked %0d output bytes over three idle/stall mixes in %0d cycles.",
             n_checked, cycle_count);
    if (mismatch_count == 0 && expected_stream.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: websocket_frame_encoder.f
rtl/wsfe_pkg.sv
rtl/wsfe_front.sv
rtl/wsfe_queue.sv
rtl/wsfe_back.sv
rtl/websocket_frame_encoder.sv
test/testbench.sv
